FILE: rtl/core/button_click_detector_unit_assert.svh
// Assertion macros used by the checker file of the click detector.
`ifndef BUTTON_CLICK_DETECTOR_UNIT_ASSERT_SVH
`define BUTTON_CLICK_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("click detector check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("click detector check failed");

`endif

FILE: rtl/core/bcd_pkg.sv
package bcd_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PRESSED_HIGH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PRESS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLICK    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MULTI_TARGET = 3'd5;

  // Register reset values
  localparam logic        RST_PRESSED_HIGH = 1'b0;
  localparam logic [7:0]  RST_DEBOUNCE     = 8'd10;
  localparam logic [15:0] RST_LONG_PRESS   = 16'd1000;
  localparam logic [15:0] RST_SHORT_PRESS  = 16'd300;
  localparam logic [15:0] RST_MAX_CLICK    = 16'd0;
  localparam logic [7:0]  RST_MULTI_TARGET = 8'd3;

  // Click counting
  localparam logic [7:0] DOUBLE_COUNT = 8'd2;
  localparam logic [7:0] COUNT_MAX    = 8'd255;

  typedef struct packed {
    logic        pressed_high;
    logic [7:0]  debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] short_press_ms;
    logic [15:0] max_click_ms;
    logic [7:0]  multi_click_target;
  } bcd_cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        pin_level;
  } bcd_in_t;

  typedef struct packed {
    logic        is_pressed;
    logic        press_down;
    logic        press_up;
    logic        long_press;
    logic        double_click;
    logic        multi_click;
    logic        single_click;
    logic [31:0] held_ms;
  } bcd_out_t;

endpackage

FILE: rtl/core/button_click_detector_unit.sv
// Button click detector: each input word is one poll (millisecond timestamp and
// raw pin level) and yields exactly one result word with the debounced level,
// press/release, long press, double, multiple and single click flags and the
// held time. A poll passes an input register, is worked against the button
// state and lands in the result register, so one poll per clock is sustained
// while result words are taken; the combinational update of the button state
// (32-bit wrapping subtract-and-compare steps) sets that rate. A result word
// that waits stalls the input only once the input register also holds a poll.
// Registers are to be written through the plain write port only while no poll
// is in flight; the block itself does not enforce this.
module button_click_detector_unit
  import bcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bcd_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bcd_out_t               out_data
);

  bcd_cfg_t cfg;
  bcd_in_t  poll;
  logic     poll_valid;
  logic     advance;
  logic     step;
  bcd_out_t result;

  bcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result register frees when empty or taken
  assign advance  = !out_valid || out_ready;
  assign step     = poll_valid && advance;
  assign in_ready = !poll_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (in_ready) begin
      poll_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      poll <= in_data;
    end
  end

  bcd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .cfg    (cfg),
    .poll   (poll),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

FILE: rtl/core/bcd_cfg.sv
module bcd_cfg
  import bcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output bcd_cfg_t               cfg
);

  // Decode writes into the register file; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressed_high       <= RST_PRESSED_HIGH;
      cfg.debounce_ms        <= RST_DEBOUNCE;
      cfg.long_press_ms      <= RST_LONG_PRESS;
      cfg.short_press_ms     <= RST_SHORT_PRESS;
      cfg.max_click_ms       <= RST_MAX_CLICK;
      cfg.multi_click_target <= RST_MULTI_TARGET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRESSED_HIGH: cfg.pressed_high       <= cfg_data[0];
        REG_DEBOUNCE:     cfg.debounce_ms        <= cfg_data[7:0];
        REG_LONG_PRESS:   cfg.long_press_ms      <= cfg_data;
        REG_SHORT_PRESS:  cfg.short_press_ms     <= cfg_data;
        REG_MAX_CLICK:    cfg.max_click_ms       <= cfg_data;
        REG_MULTI_TARGET: cfg.multi_click_target <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/bcd_core.sv
module bcd_core
  import bcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  bcd_cfg_t cfg,
  input  bcd_in_t  poll,
  output bcd_out_t result
);

  // Button state
  logic        raw_active;
  logic [31:0] raw_change_time;
  logic        debounced;
  logic [31:0] press_time;
  logic [31:0] release_time;
  logic        long_fired;
  logic [7:0]  click_count;

  logic        raw_active_next;
  logic [31:0] raw_change_time_next;
  logic        debounced_next;
  logic [31:0] press_time_next;
  logic [31:0] release_time_next;
  logic        long_fired_next;
  logic [7:0]  click_count_next;

  logic        deb_fire;
  logic        over_limit;
  logic [31:0] now;

  assign now = poll.now_ms;

  // Work one poll: debounce, then release counting, long press, sequence end
  always_comb begin
    result = '0;

    raw_active_next      = (poll.pin_level == cfg.pressed_high);
    raw_change_time_next = (raw_active_next != raw_active) ? now : raw_change_time;

    debounced_next    = debounced;
    press_time_next   = press_time;
    release_time_next = release_time;
    long_fired_next   = long_fired;
    click_count_next  = click_count;

    deb_fire = (raw_active_next != debounced) &&
               ((now - raw_change_time_next) >= {24'd0, cfg.debounce_ms});
    over_limit = (cfg.max_click_ms != 16'd0) &&
                 ((now - press_time) > {16'd0, cfg.max_click_ms});

    if (deb_fire) begin
      debounced_next = raw_active_next;
      if (raw_active_next) begin
        press_time_next   = now;
        long_fired_next   = 1'b0;
        result.press_down = 1'b1;
      end else begin
        release_time_next = now;
        result.press_up   = 1'b1;
        if (long_fired || over_limit) begin
          click_count_next = 8'd0;
        end else if (click_count != COUNT_MAX) begin
          click_count_next    = click_count + 8'd1;
          result.double_click = (click_count_next == DOUBLE_COUNT);
          result.multi_click  = (click_count_next == cfg.multi_click_target);
        end
      end
    end

    // Fire long press once per hold
    if (debounced_next && !long_fired_next &&
        ((now - press_time_next) >= {16'd0, cfg.long_press_ms})) begin
      long_fired_next   = 1'b1;
      click_count_next  = 8'd0;
      result.long_press = 1'b1;
    end

    // End the click sequence once the gap after release runs out
    if (!debounced_next && (click_count_next != 8'd0) &&
        ((now - release_time_next) >= {16'd0, cfg.short_press_ms})) begin
      result.single_click = (click_count_next == 8'd1);
      click_count_next    = 8'd0;
    end

    result.is_pressed = debounced_next;
    result.held_ms    = debounced_next ? (now - press_time_next) : 32'd0;
  end

  // Commit state when a poll is worked
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_active      <= 1'b0;
      raw_change_time <= 32'd0;
      debounced       <= 1'b0;
      press_time      <= 32'd0;
      release_time    <= 32'd0;
      long_fired      <= 1'b0;
      click_count     <= 8'd0;
    end else if (step) begin
      raw_active      <= raw_active_next;
      raw_change_time <= raw_change_time_next;
      debounced       <= debounced_next;
      press_time      <= press_time_next;
      release_time    <= release_time_next;
      long_fired      <= long_fired_next;
      click_count     <= click_count_next;
    end
  end

endmodule

FILE: rtl/core/bcd_checker.sv
`include "button_click_detector_unit_assert.svh"

module bcd_checker
  import bcd_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input bcd_out_t out_data
);

  // Hold a stalled result word
  `BCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // An empty result register never blocks the input
  `BCD_ASSERT_NOW(a_in_open, !out_valid, in_ready)

  // A press start leaves the button pressed
  `BCD_ASSERT_NOW(a_down_pressed, out_valid && out_data.press_down, out_data.is_pressed)

  // Click counts only advance on a release
  `BCD_ASSERT_NOW(a_click_on_up,
                  out_valid && (out_data.double_click || out_data.multi_click),
                  out_data.press_up && !out_data.is_pressed)

  // Released button reports no held time
  `BCD_ASSERT_NOW(a_held_zero, out_valid && !out_data.is_pressed, out_data.held_ms == 32'd0)

endmodule

bind button_click_detector_unit bcd_checker u_checker (.*);
